FILE: hw/rtl/c_source_lexical_filter_defines.svh
// assertion macros for the c source lexical filter checker
`ifndef C_SOURCE_LEXICAL_FILTER_DEFINES_SVH
`define C_SOURCE_LEXICAL_FILTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CLF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clf same-cycle check failed");

// next-cycle implication, disabled during reset
`define CLF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clf next-cycle check failed");

`endif

FILE: hw/rtl/clf_pkg.sv
// shared types and constants of the c source lexical filter
package clf_pkg;

  // character codes
  localparam logic [7:0] CtrlZ     = 8'h1A;
  localparam logic [7:0] Newline   = 8'h0A;
  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] Slash     = 8'h2F;
  localparam logic [7:0] Star      = 8'h2A;
  localparam logic [7:0] Hash      = 8'h23;
  localparam logic [7:0] DQuote    = 8'h22;
  localparam logic [7:0] SQuote    = 8'h27;
  localparam logic [7:0] Space     = 8'h20;

  // result queue sizing (power of two depth)
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // lexer modes
  typedef enum logic [3:0] {
    M_CODE      = 4'd0,
    M_SLASH     = 4'd1,
    M_STR       = 4'd2,
    M_STR_ESC   = 4'd3,
    M_CHR       = 4'd4,
    M_CHR_ESC   = 4'd5,
    M_CMT       = 4'd6,
    M_CMT_STAR  = 4'd7,
    M_DIR       = 4'd8,
    M_DIR_SLASH = 4'd9,
    M_DIR_BSL   = 4'd10
  } lex_mode_t;

  // input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } clf_in_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_marker;
    logic       last;
  } clf_out_t;

  // one or two results caused by one input item
  typedef struct packed {
    logic     two;
    clf_out_t r0;
    clf_out_t r1;
  } clf_entry_t;

  // front to back push
  typedef struct packed {
    logic       push;
    clf_entry_t entry;
  } clf_push_t;

endpackage

FILE: hw/rtl/clf_front.sv
// front end: lexer mode tracking and classification of each source byte
module clf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  clf_pkg::clf_in_t  in_data,
  output clf_pkg::clf_push_t push_o
);

  clf_pkg::lex_mode_t mode_r, mode_nxt;
  logic               dir_r, dir_nxt;

  logic [7:0] b;
  logic       ended;

  // code-mode handling of the current byte
  clf_pkg::lex_mode_t code_mode;
  logic               code_dir_set;
  logic               code_emit;

  // directive handling of the current byte
  clf_pkg::lex_mode_t dir_mode;
  logic               dir_clear;

  clf_pkg::clf_out_t  res_byte;
  clf_pkg::clf_out_t  res_slash;
  clf_pkg::clf_out_t  res_space;
  clf_pkg::clf_out_t  res_end;

  assign b     = in_data.in_byte;
  assign ended = in_data.end_of_text || (b == clf_pkg::CtrlZ);

  // canned results
  assign res_byte  = '{out_byte: b, end_marker: 1'b0, last: 1'b1};
  assign res_slash = '{out_byte: clf_pkg::Slash, end_marker: 1'b0, last: 1'b1};
  assign res_space = '{out_byte: clf_pkg::Space, end_marker: 1'b0, last: 1'b1};
  assign res_end   = '{out_byte: 8'h00, end_marker: 1'b1, last: 1'b1};

  // byte seen in code
  always_comb begin
    code_mode    = clf_pkg::M_CODE;
    code_dir_set = 1'b0;
    code_emit    = 1'b0;
    if (b == clf_pkg::DQuote) begin
      code_mode = clf_pkg::M_STR;
    end else if (b == clf_pkg::SQuote) begin
      code_mode = clf_pkg::M_CHR;
    end else if (b == clf_pkg::Hash) begin
      code_mode    = clf_pkg::M_DIR;
      code_dir_set = 1'b1;
    end else if (b == clf_pkg::Slash) begin
      code_mode = clf_pkg::M_SLASH;
    end else begin
      code_emit = 1'b1;
    end
  end

  // byte seen in a preprocessor line
  always_comb begin
    dir_mode  = clf_pkg::M_DIR;
    dir_clear = 1'b0;
    if (b == clf_pkg::Slash) begin
      dir_mode = clf_pkg::M_DIR_SLASH;
    end else if (b == clf_pkg::Newline) begin
      dir_mode  = clf_pkg::M_CODE;
      dir_clear = 1'b1;
    end else if (b == clf_pkg::Backslash) begin
      dir_mode = clf_pkg::M_DIR_BSL;
    end
  end

  // next mode and results
  always_comb begin
    mode_nxt           = mode_r;
    dir_nxt            = dir_r;
    push_o.push        = 1'b0;
    push_o.entry.two   = 1'b0;
    push_o.entry.r0    = res_byte;
    push_o.entry.r1    = res_byte;
    if (ended) begin
      mode_nxt    = clf_pkg::M_CODE;
      dir_nxt     = 1'b0;
      push_o.push = accept;
      if (mode_r == clf_pkg::M_SLASH) begin
        push_o.entry.two     = 1'b1;
        push_o.entry.r0      = res_slash;
        push_o.entry.r0.last = 1'b0;
        push_o.entry.r1      = res_end;
      end else begin
        push_o.entry.r0 = res_end;
      end
    end else begin
      unique case (mode_r)
        clf_pkg::M_SLASH: begin
          if (b == clf_pkg::Star) begin
            mode_nxt = clf_pkg::M_CMT;
          end else begin
            mode_nxt             = code_mode;
            dir_nxt              = dir_r | code_dir_set;
            push_o.push          = accept;
            push_o.entry.two     = code_emit;
            push_o.entry.r0      = res_slash;
            push_o.entry.r0.last = !code_emit;
            push_o.entry.r1      = res_byte;
          end
        end
        clf_pkg::M_STR: begin
          if (b == clf_pkg::Backslash) begin
            mode_nxt = clf_pkg::M_STR_ESC;
          end else if (b == clf_pkg::DQuote) begin
            mode_nxt = clf_pkg::M_CODE;
          end
        end
        clf_pkg::M_STR_ESC: begin
          mode_nxt = clf_pkg::M_STR;
        end
        clf_pkg::M_CHR: begin
          if (b == clf_pkg::Backslash) begin
            mode_nxt = clf_pkg::M_CHR_ESC;
          end else if (b == clf_pkg::SQuote) begin
            mode_nxt = clf_pkg::M_CODE;
          end
        end
        clf_pkg::M_CHR_ESC: begin
          mode_nxt = clf_pkg::M_CHR;
        end
        clf_pkg::M_CMT: begin
          if (b == clf_pkg::Star) begin
            mode_nxt = clf_pkg::M_CMT_STAR;
          end
        end
        clf_pkg::M_CMT_STAR: begin
          if (b == clf_pkg::Slash) begin
            if (dir_r) begin
              mode_nxt = clf_pkg::M_DIR;
            end else begin
              mode_nxt        = clf_pkg::M_CODE;
              push_o.push     = accept;
              push_o.entry.r0 = res_space;
            end
          end else if (b != clf_pkg::Star) begin
            mode_nxt = clf_pkg::M_CMT;
          end
        end
        clf_pkg::M_DIR: begin
          mode_nxt = dir_mode;
          dir_nxt  = dir_r & !dir_clear;
        end
        clf_pkg::M_DIR_SLASH: begin
          if (b == clf_pkg::Star) begin
            mode_nxt = clf_pkg::M_CMT;
          end else begin
            mode_nxt = dir_mode;
            dir_nxt  = dir_r & !dir_clear;
          end
        end
        clf_pkg::M_DIR_BSL: begin
          if (b == clf_pkg::Newline) begin
            mode_nxt = clf_pkg::M_DIR;
          end else begin
            mode_nxt = dir_mode;
            dir_nxt  = dir_r & !dir_clear;
          end
        end
        default: begin
          // code mode, and unused codes behave the same
          mode_nxt        = code_mode;
          dir_nxt         = dir_r | code_dir_set;
          push_o.push     = accept & code_emit;
          push_o.entry.r0 = res_byte;
        end
      endcase
    end
  end

  // mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= clf_pkg::M_CODE;
      dir_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dir_r  <= dir_nxt;
    end
  end

endmodule

FILE: hw/rtl/clf_back.sv
// back end: result queue and serializer of one or two results per entry
module clf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  clf_pkg::clf_push_t  push_i,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output clf_pkg::clf_out_t   out_data
);

  clf_pkg::clf_entry_t          q_r [clf_pkg::QueueDepth];
  logic [clf_pkg::QPtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [clf_pkg::QPtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [clf_pkg::QCntW-1:0]    cnt_r, cnt_nxt;
  logic                         phase_r, phase_nxt;

  clf_pkg::clf_entry_t          head;
  logic                         xfer;
  logic                         pop;

  assign full      = (cnt_r == clf_pkg::QCntW'(clf_pkg::QueueDepth));
  assign out_valid = (cnt_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign out_data  = phase_r ? head.r1 : head.r0;

  // pop after the last result of the head entry is transferred
  assign xfer = out_valid && !out_stall;
  assign pop  = xfer && (phase_r || !head.two);

  // pointer, count and phase update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    if (push_i.push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
      phase_nxt  = 1'b0;
    end else if (xfer) begin
      phase_nxt = 1'b1;
    end
    case ({push_i.push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_i.push) begin
      q_r[wr_ptr_r] <= push_i.entry;
    end
  end

endmodule

FILE: hw/rtl/c_source_lexical_filter.sv
// top level of the c source lexical filter
// Strips string and char literals and preprocessor lines from a C byte
// stream, replaces each block comment by a space (none inside a preprocessor
// line) and passes on the other code bytes. One byte is accepted per cycle
// whenever the four-entry result queue has room; results leave one per cycle
// while out_stall is low, so a byte with two results (a held slash and
// another byte or the end of text) gives them in turn. The input stalls
// only when the queue is full, and no clearing pass is needed after reset.
module c_source_lexical_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  clf_pkg::clf_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output clf_pkg::clf_out_t  out_data
);

  clf_pkg::clf_push_t push;
  logic               full;
  logic               accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // classification of incoming bytes
  clf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push_o  (push)
  );

  // queued results toward the output
  clf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/clf_checker.sv
// port-level checker of the c source lexical filter and its bind
`include "c_source_lexical_filter_defines.svh"

module clf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input clf_pkg::clf_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input clf_pkg::clf_out_t out_data
);

  // a stalled result holds its payload
  `CLF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // an end-of-text transfer always leaves a result pending next cycle
  `CLF_ASSERT_NEXT(a_end_gives_result, in_valid && !in_stall && in_data.end_of_text, out_valid)

  // with nothing queued the input never stalls
  `CLF_ASSERT_NOW(a_empty_no_stall, !out_valid, !in_stall)

  // an end marker is the final zero result of its item
  `CLF_ASSERT_NOW(a_end_marker_form, out_valid && out_data.end_marker,
                  out_data.last && (out_data.out_byte == 8'h00))

endmodule

bind c_source_lexical_filter clf_checker u_clf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
